// File: sv/bdrs_pkg.sv
// Package with the shared types and constants of the block-decomposed range sum.
`timescale 1ns / 1ps
package bdrs_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int BLOCK_SIZE_DEF = 32;

  localparam int IDX_W = $clog2(CAPACITY_DEF);
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(CAPACITY_DEF + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ORDER = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_VAL  = 2'd1,
    PEND_BLK  = 2'd2
  } pend_e;

endpackage

// File: sv/block_decomposed_range_sum.sv
// Block-decomposed range sum: a growable store of 32-bit values with per-block sums.
// Each input transfer is an append, an update or a range query and yields exactly one
// result transfer carrying the sum, a status and the entry count after the operation.
// The entries sit in one single-port-read memory and the block sums in a second one,
// both read through a registered output. An append passes a read and a write state,
// and an update passes a divide state before them that splits the index into a
// block number and an offset by a multiplication with the reciprocal of the block
// size. A query passes the divide state and then walks the range with one memory
// read for each single entry of a partial block and one for each whole block, so
// at most 2*(BLOCK_SIZE-1)+CAPACITY/BLOCK_SIZE-2 reads. An error result or an unused
// kind goes straight to the result state, where each result waits while the output
// register is stalled. Block sums start as zero through per-block valid flags, so no
// clearing pass follows reset, and a new item is taken only after the previous result
// has been moved into the output register.
`timescale 1ns / 1ps
module block_decomposed_range_sum #(
  parameter int BLOCK_SIZE = bdrs_pkg::BLOCK_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            kind_i,
  input  bdrs_pkg::idx_t        index_i,
  input  bdrs_pkg::val_t        value_i,
  input  bdrs_pkg::idx_t        lo_i,
  input  bdrs_pkg::idx_t        hi_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bdrs_pkg::val_t        sum_o,
  output logic [1:0]            status_o,
  output bdrs_pkg::count_t      count_o
);

  localparam int CAPACITY   = bdrs_pkg::CAPACITY_DEF;
  localparam int NUM_BLOCKS = (CAPACITY + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int XW   = (CW > bdrs_pkg::IDX_W) ? CW : bdrs_pkg::IDX_W;
  localparam int BKW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int RW   = $clog2(BLOCK_SIZE) + 2;
  localparam int PW   = $clog2(CAPACITY + BLOCK_SIZE + 1);
  localparam int DIV_SH = AW + 10;
  localparam int RECIP  = ((1 << DIV_SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int MW     = AW + DIV_SH + 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_WR    = 7'b0001000,
    ST_WALK  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  bdrs_pkg::kind_e       kind_q;
  bdrs_pkg::status_e     status_q;
  bdrs_pkg::pend_e       pend_q;
  logic [CW-1:0]         cnt_q;
  logic [BKW-1:0]        tail_blk_q;
  logic [RW-1:0]         tail_off_q;
  bdrs_pkg::val_t        value_q;
  logic [AW-1:0]         addr_q;
  logic [AW-1:0]         dvd_q;
  logic                  div_cnt_q;
  logic [BKW-1:0]        blk_q;
  logic [RW-1:0]         off_q;
  logic [PW-1:0]         pos_q;
  logic [PW-1:0]         hi_q;
  bdrs_pkg::val_t        acc_q;
  logic                  out_valid_q;
  bdrs_pkg::val_t        out_sum_q;
  bdrs_pkg::status_e     out_status_q;
  bdrs_pkg::count_t      out_count_q;

  bdrs_pkg::val_t        vals_mem [CAPACITY];
  bdrs_pkg::val_t        bsum_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] bvld_q;
  bdrs_pkg::val_t        vrd_q;
  bdrs_pkg::val_t        brd_q;
  logic                  bvld_rd_q;

  logic                  accept;
  logic                  out_load;
  logic [XW-1:0]         idx_x, lo_x, hi_x, cnt_x;
  logic [MW-1:0]         quo_prod;
  logic [AW-1:0]         blk_base;
  logic                  walk_issue;
  logic                  walk_whole;
  logic                  vrd_en;
  logic                  brd_en;
  logic [AW-1:0]         vaddr;
  bdrs_pkg::val_t        bsum_base;
  bdrs_pkg::val_t        bsum_new;
  logic                  div_done;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign div_done = div_cnt_q;

  assign idx_x = XW'(index_i);
  assign lo_x  = XW'(lo_i);
  assign hi_x  = XW'(hi_i);
  assign cnt_x = XW'(cnt_q);

  assign quo_prod = MW'(dvd_q) * MW'(RECIP);
  assign blk_base = AW'(blk_q) * AW'(BLOCK_SIZE);

  assign walk_issue = (pos_q <= hi_q);
  assign walk_whole = (off_q == '0) && ((pos_q + PW'(BLOCK_SIZE - 1)) <= hi_q);

  assign vrd_en = (state_q == ST_RD) || ((state_q == ST_WALK) && walk_issue && !walk_whole);
  assign brd_en = (state_q == ST_RD) || ((state_q == ST_WALK) && walk_issue && walk_whole);
  assign vaddr  = (state_q == ST_WALK) ? pos_q[AW-1:0] : addr_q;

  assign bsum_base = bvld_rd_q ? brd_q : '0;
  assign bsum_new  = (kind_q == bdrs_pkg::KIND_APPEND) ? (bsum_base + value_q)
                                                       : (bsum_base + value_q - vrd_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            bdrs_pkg::KIND_APPEND: begin
              state_d = (cnt_q >= CW'(CAPACITY)) ? ST_DONE : ST_RD;
            end
            bdrs_pkg::KIND_UPDATE: begin
              state_d = (idx_x >= cnt_x) ? ST_DONE : ST_DIV;
            end
            bdrs_pkg::KIND_QUERY: begin
              if ((lo_x >= cnt_x) || (hi_x >= cnt_x) || (lo_x > hi_x)) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_DIV;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = (kind_q == bdrs_pkg::KIND_QUERY) ? ST_WALK : ST_RD;
        end
      end
      ST_RD:    state_d = ST_WR;
      ST_WR:    state_d = ST_DONE;
      ST_WALK: begin
        if (!walk_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tail_blk_q  <= '0;
      tail_off_q  <= '0;
      bvld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_WR) && (kind_q == bdrs_pkg::KIND_APPEND)) begin
        cnt_q <= cnt_q + 1'b1;
        if (tail_off_q == RW'(BLOCK_SIZE - 1)) begin
          tail_off_q <= '0;
          tail_blk_q <= tail_blk_q + 1'b1;
        end else begin
          tail_off_q <= tail_off_q + 1'b1;
        end
      end
      if (state_q == ST_WR) begin
        bvld_q[blk_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= bdrs_pkg::kind_e'(kind_i);
      value_q   <= value_i;
      acc_q     <= '0;
      pend_q    <= bdrs_pkg::PEND_NONE;
      div_cnt_q <= 1'b0;
      pos_q     <= PW'(lo_i);
      hi_q      <= PW'(hi_i);
      status_q  <= bdrs_pkg::STAT_OK;
      case (kind_i)
        bdrs_pkg::KIND_APPEND: begin
          addr_q <= AW'(cnt_q);
          blk_q  <= tail_blk_q;
          if (cnt_q >= CW'(CAPACITY)) begin
            status_q <= bdrs_pkg::STAT_FULL;
          end
        end
        bdrs_pkg::KIND_UPDATE: begin
          addr_q <= AW'(index_i);
          dvd_q  <= AW'(index_i);
          if (idx_x >= cnt_x) begin
            status_q <= bdrs_pkg::STAT_RANGE;
          end
        end
        bdrs_pkg::KIND_QUERY: begin
          dvd_q <= AW'(lo_i);
          if ((lo_x >= cnt_x) || (hi_x >= cnt_x)) begin
            status_q <= bdrs_pkg::STAT_RANGE;
          end else if (lo_x > hi_x) begin
            status_q <= bdrs_pkg::STAT_ORDER;
          end
        end
        default: status_q <= bdrs_pkg::STAT_OK;
      endcase
    end else begin
      case (state_q)
        ST_DIV: begin
          if (div_done) begin
            off_q <= RW'(dvd_q - blk_base);
          end else begin
            blk_q     <= quo_prod[DIV_SH +: BKW];
            div_cnt_q <= 1'b1;
          end
        end
        ST_WALK: begin
          if (walk_issue && walk_whole) begin
            pos_q  <= pos_q + PW'(BLOCK_SIZE);
            blk_q  <= blk_q + 1'b1;
            pend_q <= bdrs_pkg::PEND_BLK;
          end else if (walk_issue) begin
            pos_q  <= pos_q + 1'b1;
            pend_q <= bdrs_pkg::PEND_VAL;
            if (off_q == RW'(BLOCK_SIZE - 1)) begin
              off_q <= '0;
              blk_q <= blk_q + 1'b1;
            end else begin
              off_q <= off_q + 1'b1;
            end
          end else begin
            pend_q <= bdrs_pkg::PEND_NONE;
          end
        end
        default: pend_q <= bdrs_pkg::PEND_NONE;
      endcase
      case (pend_q)
        bdrs_pkg::PEND_VAL: acc_q <= acc_q + vrd_q;
        bdrs_pkg::PEND_BLK: acc_q <= acc_q + bsum_base;
        default:            acc_q <= acc_q;
      endcase
    end
    if (out_load) begin
      out_sum_q    <= acc_q;
      out_status_q <= status_q;
      out_count_q  <= bdrs_pkg::count_t'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (vrd_en) begin
      vrd_q <= vals_mem[vaddr];
    end
    if (brd_en) begin
      brd_q     <= bsum_mem[blk_q];
      bvld_rd_q <= bvld_q[blk_q];
    end
    if (state_q == ST_WR) begin
      vals_mem[addr_q] <= value_q;
      bsum_mem[blk_q]  <= bsum_new;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sum_o       = out_sum_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // A full-store error is only reported when the store is indeed full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == bdrs_pkg::STAT_FULL)) |->
      (count_o == bdrs_pkg::count_t'(CAPACITY)))
    else $error("full status with store not full");

  // Every error result carries a zero sum.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != bdrs_pkg::STAT_OK)) |-> (sum_o == '0))
    else $error("error result with nonzero sum");

  // A result appears only when an operation has finished.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result transfer without finished operation");

endmodule

// File: tb/sv/tb_block_decomposed_range_sum.sv
// Self-checking testbench for the block-decomposed range sum with a built-in scoreboard.
`timescale 1ns / 1ps
module tb_block_decomposed_range_sum;

  localparam int CAP = bdrs_pkg::CAPACITY_DEF;
  localparam int BSZ = bdrs_pkg::BLOCK_SIZE_DEF;
  localparam int NBLK = (CAP + BSZ - 1) / BSZ;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    bdrs_pkg::val_t    sum;
    bdrs_pkg::status_e status;
    bdrs_pkg::count_t  count;
  } range_result_t;

  class range_sum_scoreboard;
    bdrs_pkg::val_t entries [CAP];
    bdrs_pkg::val_t block_totals [NBLK];
    int unsigned stored;
    range_result_t awaited [$];
    int unsigned failures;
    int unsigned checked;
    int unsigned kind_seen [4];
    int unsigned status_seen [4];

    function new();
      foreach (entries[e]) entries[e] = '0;
      foreach (block_totals[b]) block_totals[b] = '0;
      stored = 0;
      failures = 0;
      checked = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function bdrs_pkg::val_t span_total(int unsigned from_pos, int unsigned to_pos);
      bdrs_pkg::val_t acc;
      int unsigned pos;
      acc = '0;
      pos = from_pos;
      while (pos <= to_pos) begin
        if ((pos % BSZ) == 0 && pos + BSZ - 1 <= to_pos) begin
          acc += block_totals[pos / BSZ];
          pos += BSZ;
        end else begin
          acc += entries[pos];
          pos++;
        end
      end
      return acc;
    endfunction

    function void note_input(bdrs_pkg::kind_e kind, bdrs_pkg::idx_t index,
                             bdrs_pkg::val_t value, bdrs_pkg::idx_t lo,
                             bdrs_pkg::idx_t hi);
      range_result_t r;
      r.sum = '0;
      r.status = bdrs_pkg::STAT_OK;
      case (kind)
        bdrs_pkg::KIND_APPEND: begin
          if (stored >= CAP) begin
            r.status = bdrs_pkg::STAT_FULL;
          end else begin
            entries[stored] = value;
            block_totals[stored / BSZ] += value;
            stored++;
          end
        end
        bdrs_pkg::KIND_UPDATE: begin
          if (index >= stored) begin
            r.status = bdrs_pkg::STAT_RANGE;
          end else begin
            block_totals[index / BSZ] += value - entries[index];
            entries[index] = value;
          end
        end
        bdrs_pkg::KIND_QUERY: begin
          if (lo >= stored || hi >= stored) begin
            r.status = bdrs_pkg::STAT_RANGE;
          end else if (lo > hi) begin
            r.status = bdrs_pkg::STAT_ORDER;
          end else begin
            r.sum = span_total(lo, hi);
          end
        end
        default: begin
        end
      endcase
      r.count = bdrs_pkg::count_t'(stored);
      kind_seen[kind]++;
      status_seen[r.status]++;
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_result(bdrs_pkg::val_t sum, logic [1:0] status,
                               bdrs_pkg::count_t count);
      range_result_t r;
      if (awaited.size() == 0) begin
        $error("unexpected result transfer: sum %h status %0d count %0d",
               sum, status, count);
        failures++;
        return;
      end
      r = awaited.pop_front();
      checked++;
      if (sum !== r.sum) begin
        $error("sum mismatch: expected %h, actual %h", r.sum, sum);
        failures++;
      end
      if (status !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, status);
        failures++;
      end
      if (count !== r.count) begin
        $error("count mismatch: expected %0d, actual %0d", r.count, count);
        failures++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       kind_i;
  bdrs_pkg::idx_t   index_i;
  bdrs_pkg::val_t   value_i;
  bdrs_pkg::idx_t   lo_i;
  bdrs_pkg::idx_t   hi_i;
  logic             out_valid_o;
  logic             out_stall_i;
  bdrs_pkg::val_t   sum_o;
  logic [1:0]       status_o;
  bdrs_pkg::count_t count_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  range_sum_scoreboard sb;

  block_decomposed_range_sum i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .lo_i        (lo_i),
    .hi_i        (hi_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_o       (sum_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(sum_o, status_o, count_o);
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("No transfer for %0d cycles.", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input bdrs_pkg::kind_e kind, input bdrs_pkg::idx_t index,
                           input bdrs_pkg::val_t value, input bdrs_pkg::idx_t lo,
                           input bdrs_pkg::idx_t hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    index_i    <= index;
    value_i    <= value;
    lo_i       <= lo;
    hi_i       <= hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(kind, index, value, lo, hi);
  endtask

  // Hold off the sender until every outstanding result has been checked.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic bdrs_pkg::val_t pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int unsigned append_pct);
    int unsigned pick;
    int unsigned n;
    int unsigned span_end;
    bdrs_pkg::kind_e kind;
    bdrs_pkg::idx_t index;
    bdrs_pkg::idx_t lo;
    bdrs_pkg::idx_t hi;
    n = sb.stored;
    pick = $urandom_range(0, 99);
    index = bdrs_pkg::idx_t'($urandom);
    lo = bdrs_pkg::idx_t'($urandom);
    hi = bdrs_pkg::idx_t'($urandom);
    if (pick < append_pct) kind = bdrs_pkg::KIND_APPEND;
    else if (pick < append_pct + 15) kind = bdrs_pkg::KIND_UPDATE;
    else if (pick < 97) kind = bdrs_pkg::KIND_QUERY;
    else kind = bdrs_pkg::KIND_NONE;
    if (kind == bdrs_pkg::KIND_UPDATE && n > 0 && $urandom_range(0, 9) != 0) begin
      index = bdrs_pkg::idx_t'($urandom_range(0, n - 1));
    end
    if (kind == bdrs_pkg::KIND_QUERY && n > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          lo = bdrs_pkg::idx_t'($urandom_range(0, n - 1));
          hi = bdrs_pkg::idx_t'($urandom_range(lo, n - 1));
        end
        5, 6, 7: begin
          lo = bdrs_pkg::idx_t'(BSZ * $urandom_range(0, (n - 1) / BSZ));
          span_end = lo + BSZ * $urandom_range(1, 8) - 1;
          hi = bdrs_pkg::idx_t'((span_end < n) ? span_end : n - 1);
        end
        8: begin
          if (n > 1) begin
            hi = bdrs_pkg::idx_t'($urandom_range(0, n - 2));
            lo = bdrs_pkg::idx_t'($urandom_range(hi + 1, n - 1));
          end
        end
        default: begin
        end
      endcase
    end
    send_item(kind, index, pick_value(), lo, hi);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned items, input int unsigned append_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_random(append_pct);
    wait_drained();
  endtask

  initial begin
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= bdrs_pkg::KIND_APPEND;
    index_i     <= '0;
    value_i     <= '0;
    lo_i        <= '0;
    hi_i        <= '0;
    out_stall_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 14;
    recv_stall_pct = 52;
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, '0, '0);
    send_item(bdrs_pkg::KIND_UPDATE, '0, 32'h1234_5678, '0, '0);
    send_item(bdrs_pkg::KIND_NONE, '1, '1, '1, '1);
    send_item(bdrs_pkg::KIND_APPEND, '0, 32'hFFFF_FFFF, '0, '0);
    send_item(bdrs_pkg::KIND_APPEND, '1, 32'h0000_0000, '1, '1);
    send_item(bdrs_pkg::KIND_APPEND, '0, 32'h0000_0001, '0, '0);
    send_item(bdrs_pkg::KIND_APPEND, '0, 32'h8000_0000, '0, '0);
    send_item(bdrs_pkg::KIND_APPEND, '0, 32'h7FFF_FFFF, '0, '0);
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, 10'd0, 10'd4);
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, 10'd2, 10'd2);
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, 10'd4, 10'd1);
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, 10'd1, 10'd5);
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, 10'd5, 10'd1);
    send_item(bdrs_pkg::KIND_UPDATE, 10'd4, 32'h0000_0000, '0, '0);
    send_item(bdrs_pkg::KIND_UPDATE, 10'd1, 32'hFFFF_FFFF, '0, '0);
    send_item(bdrs_pkg::KIND_UPDATE, 10'd5, 32'hDEAD_BEEF, '0, '0);
    send_item(bdrs_pkg::KIND_UPDATE, 10'd1023, 32'hDEAD_BEEF, '0, '0);
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, 10'd1023, 10'd1023);
    send_item(bdrs_pkg::KIND_QUERY, '0, '0, 10'd0, 10'd4);
    wait_drained();

    run_phase(14, 52, 420, 60);
    run_phase(52, 14, 420, 60);
    run_phase(0, 0, 400, 60);

    // Fill the store completely, then keep going so appends hit a full store.
    while (sb.stored < CAP) begin
      send_item(bdrs_pkg::KIND_APPEND, bdrs_pkg::idx_t'($urandom), pick_value(),
                bdrs_pkg::idx_t'($urandom), bdrs_pkg::idx_t'($urandom));
    end
    run_phase(0, 0, 60, 40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d appends, %0d updates, %0d queries and %0d unused kinds.",
             sb.kind_seen[bdrs_pkg::KIND_APPEND], sb.kind_seen[bdrs_pkg::KIND_UPDATE],
             sb.kind_seen[bdrs_pkg::KIND_QUERY], sb.kind_seen[bdrs_pkg::KIND_NONE]);
    $display("Checked %0d results: ok %0d, index range %0d, store full %0d, order %0d.",
             sb.checked, sb.status_seen[bdrs_pkg::STAT_OK],
             sb.status_seen[bdrs_pkg::STAT_RANGE], sb.status_seen[bdrs_pkg::STAT_FULL],
             sb.status_seen[bdrs_pkg::STAT_ORDER]);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bdrs_pkg.sv
sv/block_decomposed_range_sum.sv
tb/sv/tb_block_decomposed_range_sum.sv
